/* hdl/fixed_partition_fit_allocator_core_assert.svh */
// Assertion macros for the fixed-partition fit allocator checker.
// Used by the checker module only; needs nothing else.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define FPFA_AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpfa assertion failed");

// Next-cycle implication, disabled while reset is low
`define FPFA_AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpfa assertion failed");

`endif

/* hdl/fpfa_pkg.sv */
// Shared types and constants for the fixed-partition fit allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fpfa_pkg;

    // Parameter defaults
    localparam int SLOT_COUNT_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // Stream field layout (same on request and result side)
    localparam int SLOT_W    = 4;
    localparam int VALUE_W   = 16;
    localparam int SLOT_LSB  = 0;
    localparam int VALUE_LSB = SLOT_LSB + SLOT_W;
    localparam int TDATA_W   = 24;

    // Request kinds carried in tuser
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_ALLOC = 1'b1
    } t_op;

    // Fit policy codes
    localparam logic MODE_FIRST = 1'b0;
    localparam logic MODE_BEST  = 1'b1;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic wr;         // load this slot's size
        logic take;       // mark this slot used
        logic best_mode;  // best-fit policy active
    } t_cell_ctl;

endpackage

`default_nettype wire

/* hdl/fpfa_cell.sv */
// One partition slot of the allocator chain: holds size, loaded and used
// flags, and refines the search token passing through. Depends on fpfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpfa_cell
    import fpfa_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    parameter int IDX_W     = 4,
    parameter int CELL_IDX  = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [SIZE_BITS-1:0] i_size,
    input  wire logic [SIZE_BITS-1:0] i_need,
    input  wire logic                 i_tok_vld,
    input  wire logic                 i_tok_found,
    input  wire logic [IDX_W-1:0]     i_tok_pick,
    input  wire logic [SIZE_BITS-1:0] i_tok_best,
    output logic                      o_tok_vld,
    output logic                      o_tok_found,
    output logic [IDX_W-1:0]          o_tok_pick,
    output logic [SIZE_BITS-1:0]      o_tok_best
);

    logic [SIZE_BITS-1:0] r_size;
    logic                 r_loaded;
    logic                 r_used;
    logic                 r_tok_vld;
    logic                 r_tok_found;
    logic [IDX_W-1:0]     r_tok_pick;
    logic [SIZE_BITS-1:0] r_tok_best;

    logic                 w_fits;
    logic [SIZE_BITS-1:0] w_waste;
    logic                 w_upd;
    logic                 n_tok_found;
    logic [IDX_W-1:0]     n_tok_pick;
    logic [SIZE_BITS-1:0] n_tok_best;

    // Compare this slot against the request and the best so far
    always_comb begin
        w_fits  = r_loaded && !r_used && (r_size >= i_need);
        w_waste = r_size - i_need;
        w_upd   = w_fits && (!i_tok_found ||
                  ((i_ctl.best_mode == MODE_BEST) && (w_waste < i_tok_best)));
        n_tok_found = i_tok_found || w_upd;
        n_tok_pick  = w_upd ? IDX_W'(CELL_IDX) : i_tok_pick;
        n_tok_best  = w_upd ? w_waste : i_tok_best;
    end

    // Slot flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded  <= 1'b0;
            r_used    <= 1'b0;
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld;
            if (i_ctl.wr) begin
                r_loaded <= 1'b1;
                r_used   <= 1'b0;
            end else if (i_ctl.take) begin
                r_used <= 1'b1;
            end
        end
    end

    // Slot size and token payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_size <= i_size;
        end
        r_tok_found <= n_tok_found;
        r_tok_pick  <= n_tok_pick;
        r_tok_best  <= n_tok_best;
    end

    assign o_tok_vld   = r_tok_vld;
    assign o_tok_found = r_tok_found;
    assign o_tok_pick  = r_tok_pick;
    assign o_tok_best  = r_tok_best;

endmodule

`default_nettype wire

/* hdl/fixed_partition_fit_allocator_core.sv */
// Top level of the fixed-partition fit allocator: request sequencer,
// result registers and the chain of slot cells. Depends on fpfa_pkg, fpfa_cell.
//
//  Channel        | Dir | Handshake         | Payload
//  ---------------+-----+-------------------+-------------------------------------
//  s_axis request | in  | tvalid / tready   | tuser: operation; tdata: slot, size
//  m_axis result  | out | tvalid / tready   | tuser: placed; tdata: slot, waste
//  cfg            | in  | wr_en             | wr_data: fit mode
//
// A load goes from acceptance straight to the done state; an allocate first
// scans, with the search token walking one cell per cycle through the chain.
// The result shows on m_axis in the same cycle that tready rises again.
// Synchronous reset clears all loaded and used flags.
// A stalled result waits in the output register; a second finished result
// waits in the sequencer, which then takes no new request.
`timescale 1ns / 1ps
`default_nettype none

module fixed_partition_fit_allocator_core
    import fpfa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_wr_data,    // [0] fit_mode
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [TDATA_W-1:0] i_s_axis_tdata,   // [3:0] slot_index, [19:4] size_value
    input  wire logic               i_s_axis_tuser,   // [0] operation
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic [TDATA_W-1:0]      o_m_axis_tdata,   // [3:0] chosen_slot, [19:4] waste
    output logic                    o_m_axis_tuser    // [0] placed
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    logic                 r_fit_mode;
    logic                 r_launch;
    logic [SIZE_BITS-1:0] r_need;
    logic                 r_res_placed;
    logic [SLOT_W-1:0]    r_res_slot;
    logic [VALUE_W-1:0]   r_res_waste;
    logic                 r_out_vld;
    logic                 r_out_placed;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [VALUE_W-1:0]   r_out_waste;

    t_op                  w_in_op;
    logic [SLOT_W-1:0]    w_in_slot;
    logic [SIZE_BITS-1:0] w_in_size;
    logic                 w_accept;
    logic                 w_load;
    logic                 w_scan_end;
    logic                 w_take;
    logic                 w_out_free;

    logic [SLOT_COUNT:0]  w_tok_vld;
    logic [SLOT_COUNT:0]  w_tok_found;
    logic [IDX_W-1:0]     w_tok_pick [SLOT_COUNT+1];
    logic [SIZE_BITS-1:0] w_tok_best [SLOT_COUNT+1];
    t_cell_ctl            w_ctl      [SLOT_COUNT];

    // Unpack the request
    assign w_in_op    = t_op'(i_s_axis_tuser);
    assign w_in_slot  = i_s_axis_tdata[SLOT_LSB +: SLOT_W];
    assign w_in_size  = SIZE_BITS'(i_s_axis_tdata[VALUE_LSB +: VALUE_W]);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load     = w_accept && (w_in_op == OP_LOAD);
    assign w_scan_end = (r_state == ST_SCAN) && w_tok_vld[SLOT_COUNT];
    assign w_take     = w_scan_end && w_tok_found[SLOT_COUNT];
    assign w_out_free = !r_out_vld || i_m_axis_tready;

    // Inject a fresh search token at the head of the chain
    assign w_tok_vld[0]   = r_launch;
    assign w_tok_found[0] = 1'b0;
    assign w_tok_pick[0]  = '0;
    assign w_tok_best[0]  = '0;

    // Chain of slot cells
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        assign w_ctl[g].wr        = w_load && (32'(w_in_slot) == g);
        assign w_ctl[g].take      = w_take && (w_tok_pick[SLOT_COUNT] == IDX_W'(g));
        assign w_ctl[g].best_mode = r_fit_mode;

        fpfa_cell #(
            .SIZE_BITS (SIZE_BITS),
            .IDX_W     (IDX_W),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl[g]),
            .i_size      (w_in_size),
            .i_need      (r_need),
            .i_tok_vld   (w_tok_vld[g]),
            .i_tok_found (w_tok_found[g]),
            .i_tok_pick  (w_tok_pick[g]),
            .i_tok_best  (w_tok_best[g]),
            .o_tok_vld   (w_tok_vld[g+1]),
            .o_tok_found (w_tok_found[g+1]),
            .o_tok_pick  (w_tok_pick[g+1]),
            .o_tok_best  (w_tok_best[g+1])
        );
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (w_in_op == OP_LOAD) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_tok_vld[SLOT_COUNT]) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_launch   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_fit_mode <= MODE_FIRST;
        end else begin
            r_state  <= n_state;
            r_launch <= w_accept && (w_in_op == OP_ALLOC);
            if (i_cfg_wr_en) begin
                r_fit_mode <= i_cfg_wr_data;
            end
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_need <= w_in_size;
        end
        if (w_load) begin
            r_res_placed <= 1'b0;
            r_res_slot   <= w_in_slot;
            r_res_waste  <= '0;
        end else if (w_scan_end) begin
            r_res_placed <= w_tok_found[SLOT_COUNT];
            r_res_slot   <= w_tok_found[SLOT_COUNT] ?
                            SLOT_W'(w_tok_pick[SLOT_COUNT]) : '0;
            r_res_waste  <= w_tok_found[SLOT_COUNT] ?
                            VALUE_W'(w_tok_best[SLOT_COUNT]) : '0;
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out_placed <= r_res_placed;
            r_out_slot   <= r_res_slot;
            r_out_waste  <= r_res_waste;
        end
    end

    // Pack the result
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out_placed;
    assign o_m_axis_tdata  = TDATA_W'({r_out_waste, r_out_slot});

endmodule

`default_nettype wire

/* hdl/fpfa_checker.sv */
// Port-level checker for the fixed-partition fit allocator, bound to the top.
// Depends on fpfa_pkg and fixed_partition_fit_allocator_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_partition_fit_allocator_core_assert.svh"

module fpfa_checker
    import fpfa_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_s_axis_tvalid,
    input wire logic               o_s_axis_tready,
    input wire logic               o_m_axis_tvalid,
    input wire logic               i_m_axis_tready,
    input wire logic [TDATA_W-1:0] o_m_axis_tdata,
    input wire logic               o_m_axis_tuser
);

    // Hold a stalled result
    `FPFA_AST_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // A result that is not placed reports no waste
    `FPFA_AST_SAME(a_waste_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata[VALUE_LSB +: VALUE_W] == '0)

    // One request in flight: ready drops right after an accepted request
    `FPFA_AST_NEXT(a_one_in_flight, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

endmodule

bind fixed_partition_fit_allocator_core fpfa_checker u_fpfa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
